// ===== rtl/ohlc_pkg.sv =====
// Shared widths, constants and transaction types for the OHLC bar resampler.
package ohlc_pkg;

    localparam int TIME_BITS      = 40;
    localparam int PRICE_BITS     = 48;
    localparam int VOL_BITS       = 48;
    localparam int INTERVAL_BITS  = 24;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(60);

    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic        [TIME_BITS-1:0]  bar_time;
        logic signed [PRICE_BITS-1:0] open_price;
        logic signed [PRICE_BITS-1:0] high_price;
        logic signed [PRICE_BITS-1:0] low_price;
        logic signed [PRICE_BITS-1:0] close_price;
        logic        [VOL_BITS-1:0]   bar_volume;
        logic                         end_of_data;
    } t_bar_in;

    typedef struct packed {
        logic        [TIME_BITS-1:0]  period_start;
        logic signed [PRICE_BITS-1:0] out_open;
        logic signed [PRICE_BITS-1:0] out_high;
        logic signed [PRICE_BITS-1:0] out_low;
        logic signed [PRICE_BITS-1:0] out_close;
        logic        [VOL_BITS-1:0]   out_volume;
        logic                         last_bar;
    } t_bar_out;

    // Results of one input transaction: up to two bars, in order.
    typedef struct packed {
        logic [1:0] count;
        t_bar_out   first;
        t_bar_out   second;
    } t_emit;

endpackage

// ===== rtl/ohlc_period_unit.sv =====
// Open-period state, interval register and per-bar merge/emit logic.
module ohlc_period_unit
    import ohlc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [INTERVAL_BITS-1:0] i_cfg_wr_data,
    input  logic                     i_fire,
    input  t_bar_in                  i_bar,
    output t_emit                    o_emit
);

    logic [INTERVAL_BITS-1:0]     r_interval_seconds;
    logic                         r_period_open, n_period_open;
    logic        [TIME_BITS-1:0]  r_start_time, n_start_time;
    logic        [TIME_BITS-1:0]  r_end_time, n_end_time;
    logic signed [PRICE_BITS-1:0] r_acc_open, n_acc_open;
    logic signed [PRICE_BITS-1:0] r_acc_high, n_acc_high;
    logic signed [PRICE_BITS-1:0] r_acc_low, n_acc_low;
    logic signed [PRICE_BITS-1:0] r_acc_close, n_acc_close;
    logic        [VOL_BITS-1:0]   r_acc_volume, n_acc_volume;

    logic [VOL_BITS:0] vol_sum;
    t_bar_out          pass_bar;
    t_bar_out          old_bar;
    t_bar_out          eod_bar;
    logic              emitted_old;
    t_emit             emit;

    function automatic logic [TIME_BITS-1:0] time_add_sat(
        input logic [TIME_BITS-1:0]     t,
        input logic [INTERVAL_BITS-1:0] d
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS + 1)'(d);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    assign vol_sum = {1'b0, r_acc_volume} + {1'b0, i_bar.bar_volume};

    always_comb begin
        n_period_open = r_period_open;
        n_start_time  = r_start_time;
        n_end_time    = r_end_time;
        n_acc_open    = r_acc_open;
        n_acc_high    = r_acc_high;
        n_acc_low     = r_acc_low;
        n_acc_close   = r_acc_close;
        n_acc_volume  = r_acc_volume;
        emitted_old   = 1'b0;
        emit          = '0;
        eod_bar       = '0;

        pass_bar.period_start = i_bar.bar_time;
        pass_bar.out_open     = i_bar.open_price;
        pass_bar.out_high     = i_bar.high_price;
        pass_bar.out_low      = i_bar.low_price;
        pass_bar.out_close    = i_bar.close_price;
        pass_bar.out_volume   = i_bar.bar_volume;
        pass_bar.last_bar     = i_bar.end_of_data;

        old_bar.period_start  = r_start_time;
        old_bar.out_open      = r_acc_open;
        old_bar.out_high      = r_acc_high;
        old_bar.out_low       = r_acc_low;
        old_bar.out_close     = r_acc_close;
        old_bar.out_volume    = r_acc_volume;
        old_bar.last_bar      = 1'b0;

        if (r_interval_seconds == '0) begin
            // pass-through; an open period is flushed ahead of the bar
            n_period_open = 1'b0;
            if (r_period_open) begin
                emit.first  = old_bar;
                emit.second = pass_bar;
                emit.count  = 2'd2;
            end else begin
                emit.first = pass_bar;
                emit.count = 2'd1;
            end
        end else begin
            if (!r_period_open || (i_bar.bar_time >= r_end_time)) begin
                if (!r_period_open) begin
                    n_start_time = i_bar.bar_time;
                    n_end_time   = time_add_sat(i_bar.bar_time, r_interval_seconds);
                end else begin
                    // period closed: next one starts at old end, one interval only
                    emitted_old  = 1'b1;
                    emit.first   = old_bar;
                    emit.count   = 2'd1;
                    n_start_time = r_end_time;
                    n_end_time   = time_add_sat(r_end_time, r_interval_seconds);
                end
                n_period_open = 1'b1;
                n_acc_open    = i_bar.open_price;
                n_acc_high    = i_bar.high_price;
                n_acc_low     = i_bar.low_price;
                n_acc_close   = i_bar.close_price;
                n_acc_volume  = i_bar.bar_volume;
            end else begin
                if (i_bar.high_price > r_acc_high) begin
                    n_acc_high = i_bar.high_price;
                end
                if (i_bar.low_price < r_acc_low) begin
                    n_acc_low = i_bar.low_price;
                end
                n_acc_close  = i_bar.close_price;
                n_acc_volume = vol_sum[VOL_BITS] ? {VOL_BITS{1'b1}} : vol_sum[VOL_BITS-1:0];
            end

            // flush record built from the updated period
            eod_bar.period_start = n_start_time;
            eod_bar.out_open     = n_acc_open;
            eod_bar.out_high     = n_acc_high;
            eod_bar.out_low      = n_acc_low;
            eod_bar.out_close    = n_acc_close;
            eod_bar.out_volume   = n_acc_volume;
            eod_bar.last_bar     = 1'b1;

            if (i_bar.end_of_data) begin
                n_period_open = 1'b0;
                if (emitted_old) begin
                    emit.second = eod_bar;
                    emit.count  = 2'd2;
                end else begin
                    emit.first = eod_bar;
                    emit.count = 2'd1;
                end
            end
        end

        if (!i_fire) begin
            emit.count = 2'd0;
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_seconds <= INTERVAL_RESET;
            r_period_open      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval_seconds <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_period_open <= n_period_open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_start_time <= n_start_time;
            r_end_time   <= n_end_time;
            r_acc_open   <= n_acc_open;
            r_acc_high   <= n_acc_high;
            r_acc_low    <= n_acc_low;
            r_acc_close  <= n_acc_close;
            r_acc_volume <= n_acc_volume;
        end
    end

endmodule

// ===== rtl/ohlc_out_fifo.sv =====
// Small result queue: takes up to two bars per cycle, hands out one per cycle unless stalled.
module ohlc_out_fifo
    import ohlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_emit    i_emit,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_stall,
    output t_bar_out o_data
);

    t_bar_out                r_mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [OUT_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUT_CNT_BITS-1:0] r_count, n_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // room for a two-bar transaction
    assign o_room  = (r_count <= OUT_CNT_BITS'(OUT_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + OUT_PTR_BITS'(i_emit.count);
        n_rd_ptr = r_rd_ptr + OUT_PTR_BITS'(pop);
        n_count  = r_count + OUT_CNT_BITS'(i_emit.count) - OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[r_wr_ptr + OUT_PTR_BITS'(1)] <= i_emit.second;
        end
    end

endmodule

// ===== rtl/ohlc_bar_resampler.sv =====
// OHLC bar resampler: merges a time-ordered bar stream into bars of a set interval.
// One input transaction is taken per clock unless o_in_stall is high. A transaction
// is held in an input register, merged into the open period once the result queue
// has room, and its results land in a four-entry result queue, so every result
// passes through the input register and the queue before it is offered. Most bars
// give zero or one result; a bar that both closes a period and carries end_of_data,
// or a bar arriving with interval 0 while a period is open, gives two, which the
// single output port drains one at a time. The input side keeps taking one bar per
// cycle as long as the queue holds at most two bars; a stalled output fills it and
// stalls the input. The interval register resets to 60 and is written through
// i_cfg_wr_en and i_cfg_wr_data; the user must write it only while no transaction
// is in flight, and the block itself does not enforce this. 0 passes bars through.
module ohlc_bar_resampler
    import ohlc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [INTERVAL_BITS-1:0] i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_bar_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_bar_out                 o_out_data
);

    logic    r_in_valid;
    t_bar_in r_in;
    logic    room;
    logic    fire;
    logic    accept;
    t_emit   emit;

    // Input stage advances when the queue can absorb a two-bar transaction.
    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    ohlc_period_unit u_period (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_bar         (r_in),
        .o_emit        (emit)
    );

    ohlc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ===== sim/ohlc_checker.sv =====
// Checker for the OHLC bar resampler: tracks the open period and compares every emitted bar.
`timescale 1ns / 100ps

module ohlc_checker
    import ohlc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [INTERVAL_BITS-1:0] i_cfg_wr_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_bar_in                  i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_bar_out                 i_out_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    // keep the log short when the block is badly broken; every mismatch still counts
    localparam int PRINT_LIMIT = 100;

    logic [INTERVAL_BITS-1:0]     interval;
    logic                         period_open;
    logic [TIME_BITS-1:0]         period_begin;
    logic [TIME_BITS-1:0]         period_end;
    logic signed [PRICE_BITS-1:0] acc_open;
    logic signed [PRICE_BITS-1:0] acc_high;
    logic signed [PRICE_BITS-1:0] acc_low;
    logic signed [PRICE_BITS-1:0] acc_close;
    logic [VOL_BITS-1:0]          acc_volume;
    t_bar_out                     expected_bars[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // period end, saturating at the largest timestamp
    function automatic logic [TIME_BITS-1:0] add_interval(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, t} + (TIME_BITS + 1)'(interval);
        return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    function automatic t_bar_out closed_period(input logic last);
        t_bar_out r;
        r.period_start = period_begin;
        r.out_open     = acc_open;
        r.out_high     = acc_high;
        r.out_low      = acc_low;
        r.out_close    = acc_close;
        r.out_volume   = acc_volume;
        r.last_bar     = last;
        return r;
    endfunction

    task automatic seed_period(input t_bar_in b);
        acc_open   = b.open_price;
        acc_high   = b.high_price;
        acc_low    = b.low_price;
        acc_close  = b.close_price;
        acc_volume = b.bar_volume;
    endtask

    // append one predicted bar at the tail of the queue
    task automatic queue_bar(input t_bar_out b);
        expected_bars = {expected_bars, b};
    endtask

    // one input bar: update the period and queue the bars it emits
    task automatic merge_bar(input t_bar_in b);
        t_bar_out          passed;
        logic [VOL_BITS:0] vol_sum;
        if (interval == '0) begin
            if (period_open) begin
                queue_bar(closed_period(1'b0));
                period_open = 1'b0;
            end
            passed.period_start = b.bar_time;
            passed.out_open     = b.open_price;
            passed.out_high     = b.high_price;
            passed.out_low      = b.low_price;
            passed.out_close    = b.close_price;
            passed.out_volume   = b.bar_volume;
            passed.last_bar     = b.end_of_data;
            queue_bar(passed);
        end else begin
            if (!period_open) begin
                period_begin = b.bar_time;
                period_end   = add_interval(b.bar_time);
                seed_period(b);
                period_open  = 1'b1;
            end else if (b.bar_time < period_end) begin
                if ($signed(b.high_price) > $signed(acc_high)) acc_high = b.high_price;
                if ($signed(b.low_price) < $signed(acc_low)) acc_low = b.low_price;
                acc_close  = b.close_price;
                vol_sum    = {1'b0, acc_volume} + {1'b0, b.bar_volume};
                acc_volume = vol_sum[VOL_BITS] ? '1 : vol_sum[VOL_BITS-1:0];
            end else begin
                // next period is one interval on, however far the bar jumped
                queue_bar(closed_period(1'b0));
                period_begin = period_end;
                period_end   = add_interval(period_end);
                seed_period(b);
            end
            if (b.end_of_data) begin
                queue_bar(closed_period(1'b1));
                period_open = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (o_fail_count < PRINT_LIMIT)
            $display("%0t: %s got %h expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_bar(input t_bar_out got);
        t_bar_out want;
        if (expected_bars.size() == 0) begin
            report_mismatch("bar with nothing expected, period_start", got.period_start, '0);
            return;
        end
        want = expected_bars.pop_front();
        if (got.period_start !== want.period_start)
            report_mismatch("period_start", got.period_start, want.period_start);
        if (got.out_open !== want.out_open)
            report_mismatch("out_open", got.out_open, want.out_open);
        if (got.out_high !== want.out_high)
            report_mismatch("out_high", got.out_high, want.out_high);
        if (got.out_low !== want.out_low)
            report_mismatch("out_low", got.out_low, want.out_low);
        if (got.out_close !== want.out_close)
            report_mismatch("out_close", got.out_close, want.out_close);
        if (got.out_volume !== want.out_volume)
            report_mismatch("out_volume", got.out_volume, want.out_volume);
        if (got.last_bar !== want.last_bar)
            report_mismatch("last_bar", got.last_bar, want.last_bar);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            interval     = INTERVAL_RESET;
            period_open  = 1'b0;
            period_begin = '0;
            period_end   = '0;
            acc_open     = '0;
            acc_high     = '0;
            acc_low      = '0;
            acc_close    = '0;
            acc_volume   = '0;
            expected_bars.delete();
        end else begin
            if (i_cfg_wr_en) interval = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) check_bar(i_out_data);
            if (i_in_valid && !i_in_stall) merge_bar(i_in_data);
        end
        o_pending = expected_bars.size();
    end

endmodule

// ===== sim/tb_ohlc_bar_resampler.sv =====
// Testbench top for the OHLC bar resampler: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_ohlc_bar_resampler;
    import ohlc_pkg::*;

    // Cycles with no transaction on any port before the run is called hung.
    // Worst honest stretch is the long output hold-off plus a sender gap.
    localparam int STALL_LIMIT = 2000;
    // long receiver hold-off; the result queue is four deep, so this fills it
    localparam int HOLD_CYCLES = 80;
    // extra cycles after the last result: a bar that emits nothing may still
    // be in the input register or the merge stage
    localparam int DRAIN_PAD   = 6;
    localparam int PHASE_BARS  = 195;

    localparam logic [TIME_BITS-1:0]         TIME_MAX     = '1;
    localparam logic signed [PRICE_BITS-1:0] PRICE_MAX    = {1'b0, {(PRICE_BITS-1){1'b1}}};
    localparam logic signed [PRICE_BITS-1:0] PRICE_MIN    = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam logic [VOL_BITS-1:0]          VOL_MAX      = '1;
    localparam logic [INTERVAL_BITS-1:0]     INTERVAL_MAX = '1;

    // receiver stall patterns
    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HALF, FLOW_HEAVY} t_flow;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [INTERVAL_BITS-1:0] i_cfg_wr_data = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    t_bar_in                  i_in_data     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b0;
    t_bar_out                 o_out_data;

    int   fail_count;
    int   pending;
    int   bars_sent      = 0;
    int   burst_left     = 0;
    int   quiet_cycles   = 0;
    // raised by the stimulus, cleared by the receiver when it starts the hold-off
    logic hold_req       = 1'b0;

    ohlc_bar_resampler DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    ohlc_checker bar_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Sender side. Every task starts and ends just after a rising edge, so
    // each input gets at most one nonblocking update per time step. Stall is
    // looked at on the falling edge, where nothing is moving.
    // ---------------------------------------------------------------------

    // offer one bar and hold it until the transaction completes
    task automatic send_bar(input t_bar_in b);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        bars_sent++;
    endtask

    task automatic idle_for(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // bursts of random length, short random gaps between them; now and then
    // a long burst so the block sees a full-rate stream
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_for($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // stop offering, wait for every predicted bar, then let the pipeline empty
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // the interval register is only touched with nothing in flight
    task automatic set_interval(input logic [INTERVAL_BITS-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly full-range prices, with the extremes and values near zero mixed in
    function automatic logic signed [PRICE_BITS-1:0] rand_price();
        logic [63:0] w;
        w = rand64();
        case ($urandom_range(0, 9))
            0:       return PRICE_MAX;
            1:       return PRICE_MIN;
            2:       return PRICE_BITS'($signed(w[15:0]));
            default: return w[PRICE_BITS-1:0];
        endcase
    endfunction

    // small volumes keep sums honest; near-max ones push the sum into saturation
    function automatic logic [VOL_BITS-1:0] rand_volume();
        logic [63:0] w;
        w = rand64();
        case ($urandom_range(0, 7))
            0:       return VOL_MAX - w[7:0];
            1:       return w[VOL_BITS-1:0];
            2:       return '0;
            default: return VOL_BITS'(w[23:0]);
        endcase
    endfunction

    function automatic t_bar_in make_bar(input logic [TIME_BITS-1:0] t, input logic eod);
        t_bar_in b;
        b.bar_time    = t;
        b.open_price  = rand_price();
        b.high_price  = rand_price();
        b.low_price   = rand_price();
        b.close_price = rand_price();
        b.bar_volume  = rand_volume();
        b.end_of_data = eod;
        return b;
    endfunction

    // One series of bars with roughly increasing timestamps. Steps are mostly
    // inside the interval, some jump past one or more period ends, a few go
    // backwards. Series sometimes start near the top of the time range so the
    // period end saturates. The last bar usually carries end_of_data.
    task automatic run_series(input longint unsigned span, input int n_bars);
        logic [TIME_BITS-1:0] t;
        logic [63:0]          w;
        longint unsigned      back;
        logic                 eod;
        w    = rand64();
        back = w[31:0] % (3 * span + 8);
        t    = ($urandom_range(0, 5) == 0) ? TIME_MAX - TIME_BITS'(back) : w[TIME_BITS-1:0];
        for (int k = 0; k < n_bars; k++) begin
            w = rand64();
            if (k > 0) begin
                case ($urandom_range(0, 19))
                    0, 1:    t = t - TIME_BITS'(w[31:0] % (span + 1));
                    2, 3, 4: t = t + TIME_BITS'(span + w[31:0] % (2 * span + 1));
                    default: t = t + TIME_BITS'(w[31:0] % span);
                endcase
            end
            eod = (k == n_bars - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
            send_bar(make_bar(t, eod));
            pace();
        end
    endtask

    // One interval setting: well-formed series plus, about one time in ten, a single
    // bar of pure noise (random time, random end_of_data).
    task automatic run_phase(input logic [INTERVAL_BITS-1:0] value, input int n_target,
                             input logic with_hold);
        longint unsigned span;
        int              goal;
        set_interval(value);
        span = (value == '0) ? 10 : value;
        goal = bars_sent + n_target;
        // receiver holds off while the sender keeps pushing: queue fills, input stalls
        if (with_hold) hold_req = 1'b1;
        while (bars_sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_bar(make_bar(TIME_BITS'(rand64()), 1'(($urandom_range(0, 1)))));
                pace();
            end else begin
                run_series(span, $urandom_range(1, 30));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver: segments of its own stall pattern, including free-flowing
    // stretches, and the long hold-off on request.
    // ---------------------------------------------------------------------
    initial begin : receiver
        t_flow flow;
        int    seg_len;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                flow    = t_flow'($urandom_range(0, 3));
                seg_len = $urandom_range(1, 40);
                repeat (seg_len) begin
                    @(posedge i_clk);
                    case (flow)
                        FLOW_FREE:  i_out_stall <= 1'b0;
                        FLOW_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                        FLOW_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
                        FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 9) != 0);
                        default:    i_out_stall <= 1'b0;
                    endcase
                end
            end
        end
    end

    // hang detector: any transaction on any port restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("tb_ohlc_bar_resampler failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset interval (60). Open a period at 100 with extreme prices and
        // full volume; an earlier bar merges and saturates the volume; a bar
        // just under the end merges without moving high or low.
        send_bar(t_bar_in'{40'd100, PRICE_MAX, PRICE_MAX, PRICE_MIN, '0, VOL_MAX, 1'b0});
        send_bar(t_bar_in'{40'd40, 48'sd1, 48'sd5, PRICE_MIN + 1, -48'sd9, 48'd5, 1'b0});
        send_bar(t_bar_in'{40'd159, -48'sd3, -48'sd3, 48'sd0, 48'sd7, '0, 1'b0});
        // exactly at the end: emits, next period starts at 160
        send_bar(t_bar_in'{40'd160, PRICE_MIN, 48'sd2, PRICE_MIN, PRICE_MAX, 48'd1, 1'b0});
        // far past the end with end_of_data: two bars, the second starting at 220
        send_bar(t_bar_in'{40'd1000, 48'sd4, PRICE_MAX, -48'sd4, 48'sd4, VOL_MAX, 1'b1});
        // near the top of time: period end saturates, then start lands on the max
        send_bar(t_bar_in'{TIME_MAX - 30, -48'sd1, 48'sd1, -48'sd2, 48'sd0, 48'd3, 1'b0});
        send_bar(t_bar_in'{TIME_MAX, PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN, 48'd9, 1'b0});
        send_bar(t_bar_in'{'0, 48'sd8, PRICE_MAX, PRICE_MIN, 48'sd8, VOL_MAX, 1'b1});

        // pass-through with nothing open
        set_interval('0);
        send_bar(t_bar_in'{40'd12345, PRICE_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN, '0, 1'b0});
        send_bar(t_bar_in'{TIME_MAX, PRICE_MIN, PRICE_MAX, PRICE_MIN, PRICE_MAX, VOL_MAX, 1'b1});

        // widest interval, then switch to pass-through with the period still open
        set_interval(INTERVAL_MAX);
        send_bar(t_bar_in'{40'd5, 48'sd10, 48'sd20, 48'sd1, 48'sd15, 48'd100, 1'b0});
        send_bar(t_bar_in'{40'd16777219, 48'sd11, 48'sd30, -48'sd5, 48'sd12, 48'd7, 1'b0});
        set_interval('0);
        send_bar(t_bar_in'{40'd7, -48'sd7, 48'sd7, -48'sd7, 48'sd7, 48'd7, 1'b0});

        // shortest interval
        set_interval(24'd1);
        send_bar(t_bar_in'{40'd10, 48'sd1, 48'sd2, 48'sd0, 48'sd1, 48'd1, 1'b0});
        send_bar(t_bar_in'{40'd10, 48'sd2, 48'sd3, -48'sd1, 48'sd2, 48'd1, 1'b0});
        send_bar(t_bar_in'{40'd11, 48'sd3, 48'sd4, 48'sd2, 48'sd3, 48'd1, 1'b0});
        send_bar(t_bar_in'{40'd500, 48'sd4, 48'sd5, 48'sd3, 48'sd4, 48'd1, 1'b1});

        // Random part. Every phase begins with a full drain, so the sender
        // waits for all outstanding bars several times over.
        run_phase(24'd1, PHASE_BARS, 1'b0);
        run_phase(24'd2, PHASE_BARS, 1'b1);
        run_phase(24'd7, PHASE_BARS, 1'b0);
        run_phase(INTERVAL_RESET, PHASE_BARS, 1'b0);
        run_phase('0, PHASE_BARS, 1'b1);
        run_phase(24'd3, PHASE_BARS, 1'b0);
        run_phase(INTERVAL_MAX, PHASE_BARS, 1'b0);
        run_phase(24'd1000, PHASE_BARS, 1'b0);
        run_phase(INTERVAL_BITS'($urandom_range(1, INTERVAL_MAX)), PHASE_BARS, 1'b1);
        run_phase(24'd1, PHASE_BARS, 1'b0);

        drain();
        if (fail_count == 0) begin
            $display("tb_ohlc_bar_resampler passed");
        end else begin
            $display("tb_ohlc_bar_resampler failed");
        end
        $finish;
    end

endmodule
